@@ hdl/pwac_pkg.sv @@
package pwac_pkg;

	// fixed widths of the ports
	localparam int SEED_W = 32;
	localparam int CNT_W  = 32;

	// defaults
	localparam int          SIDE_DEFAULT = 4;
	localparam int          SIDE_MAX     = 5;
	localparam logic [31:0] LIMIT_RESET  = 32'd100000000;

	// per-cycle orders from the search control to every cell
	typedef struct packed {
		logic load;     // take the seed into hare and tortoise
		logic step;     // advance the hare lattice by one step
		logic capture;  // tortoise takes the current hare value
	} pwac_cell_ctl_t;

endpackage

@@ hdl/pwac_cell.sv @@
module pwac_cell
	import pwac_pkg::*;
(
	input  logic           clk,
	input  pwac_cell_ctl_t ctl,
	input  logic           seed_cur,
	input  logic           seed_prev,
	input  logic           nb_east,
	input  logic           nb_west,
	input  logic           nb_north,
	input  logic           nb_south,
	output logic           cur,
	output logic           match
);

	logic hare_cur_q;
	logic hare_prev_q;
	logic tort_cur_q;
	logic tort_prev_q;
	logic next_cur;

	// wave rule: neighbours' current bits against own previous bit
	assign next_cur = nb_east ^ nb_west ^ nb_north ^ nb_south ^ hare_prev_q;

	// hare site
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hare_cur_q  <= seed_cur;
			hare_prev_q <= seed_prev;
		end else if (ctl.step) begin
			hare_cur_q  <= next_cur;
			hare_prev_q <= hare_cur_q;
		end
	end

	// tortoise site
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tort_cur_q  <= seed_cur;
			tort_prev_q <= seed_prev;
		end else if (ctl.capture) begin
			tort_cur_q  <= hare_cur_q;
			tort_prev_q <= hare_prev_q;
		end
	end

	assign cur   = hare_cur_q;
	assign match = (hare_cur_q == tort_cur_q) && (hare_prev_q == tort_prev_q);

endmodule

@@ hdl/parity_wave_automaton_cycle_finder.sv @@
// channel   | handshake                 | beat
// ----------+---------------------------+--------------------------------
// seed in   | start, busy               | start_state
// config    | cfg_valid, cfg_ready      | max_iterations
// result    | done (one-cycle strobe)   | cycle_length, found
//
// A seed beat is taken when start is high and busy low. The next cycle primes the
// hare one lattice step ahead, then the grid of site cells advances the hare one
// step per cycle while the counters run Brent's search; done strobes in the cycle
// after the last check, registered from it. busy stays high until done.
// arst_n clears the control and the limit (back to 100000000). done cannot be
// held off by the receiver; cfg_ready is always high.
module parity_wave_automaton_cycle_finder
	import pwac_pkg::*;
#(
	parameter int SIDE = SIDE_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [SEED_W-1:0] start_state,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  max_iterations,
	output logic              done,
	output logic [CNT_W-1:0]  cycle_length,
	output logic              found
);

	localparam int SITES = SIDE * SIDE;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] power_q;
	logic [CNT_W-1:0] lambda_q;
	logic             done_q;
	logic [CNT_W-1:0] cycle_length_q;
	logic             found_q;

	pwac_cell_ctl_t   ctl;
	logic [SITES-1:0] cur_vec;
	logic [SITES-1:0] match_vec;
	logic             accept;
	logic             same;
	logic             at_limit;
	logic             finish;
	logic             catch_up;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// search decisions on the registered counters
	assign same     = &match_vec;
	assign at_limit = (lambda_q >= limit_q);
	assign finish   = (state_q == ST_RUN) && (same || at_limit);
	assign catch_up = (power_q == lambda_q);

	// cell orders
	always_comb begin
		ctl.load    = accept;
		ctl.step    = (state_q == ST_PRIME) || ((state_q == ST_RUN) && !finish);
		ctl.capture = (state_q == ST_RUN) && !finish && catch_up;
	end

	// grid of site cells on the torus
	for (genvar y = 0; y < SIDE; y++) begin : g_row
		for (genvar x = 0; x < SIDE; x++) begin : g_col
			localparam int SITE = x + SIDE * y;
			localparam int EAST  = ((x + 1) % SIDE) + SIDE * y;
			localparam int WEST  = ((x + SIDE - 1) % SIDE) + SIDE * y;
			localparam int NORTH = x + SIDE * ((y + 1) % SIDE);
			localparam int SOUTH = x + SIDE * ((y + SIDE - 1) % SIDE);
			logic seed_cur;
			logic seed_prev;

			// seed bits past the input width start at zero
			if (2 * SITE < SEED_W) begin : g_scur
				assign seed_cur = start_state[2 * SITE];
			end else begin : g_zcur
				assign seed_cur = 1'b0;
			end
			if (2 * SITE + 1 < SEED_W) begin : g_sprev
				assign seed_prev = start_state[2 * SITE + 1];
			end else begin : g_zprev
				assign seed_prev = 1'b0;
			end

			pwac_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.seed_cur (seed_cur),
				.seed_prev(seed_prev),
				.nb_east  (cur_vec[EAST]),
				.nb_west  (cur_vec[WEST]),
				.nb_north (cur_vec[NORTH]),
				.nb_south (cur_vec[SOUTH]),
				.cur      (cur_vec[SITE]),
				.match    (match_vec[SITE])
			);
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= max_iterations;
		end
	end

	// search sequencer and Brent counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			power_q  <= '0;
			lambda_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					power_q  <= CNT_W'(1);
					lambda_q <= CNT_W'(1);
					state_q  <= ST_RUN;
				end
				ST_RUN: begin
					if (finish) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (catch_up) begin
						power_q  <= {power_q[CNT_W-2:0], 1'b0};
						lambda_q <= CNT_W'(1);
					end else begin
						lambda_q <= lambda_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (finish) begin
			found_q        <= !at_limit;
			cycle_length_q <= at_limit ? '0 : lambda_q;
		end
	end

	assign done         = done_q;
	assign cycle_length = cycle_length_q;
	assign found        = found_q;

	// result strobe only once the search has let go of busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a found period is never zero
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (cycle_length != '0))
		else $error("found with zero period");

	// an accepted seed starts the search
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("seed taken but search not started");

	// strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
